// ===== hdl/pfi_pkg.sv =====
// Shared types, codes and helpers for the probe fault injector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pfi_pkg;

  localparam int TAG_W = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = 31;
  localparam int KIND_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [4:0] BIT_MAX = 5'd31;

  // Item operations, carried on the input tuser
  typedef enum logic [1:0] {
    OP_INJECT = 2'd0,
    OP_ADD    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSTCNT = 2'd3
  } opcode_t;

  // Fault kinds; codes above KIND_SET are stored but act as none
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BITFLIP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OFFSET  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GAIN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET     = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSLOT  = 2'd1;
  localparam logic [1:0] STAT_NOPROBE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PSCAN,
    ST_SREAD,
    ST_SCHECK,
    ST_MUL,
    ST_SUM,
    ST_NORM,
    ST_SNEXT,
    ST_AFIND,
    ST_AALLOC,
    ST_DONE
  } state_t;

  // One fault slot as held in the slot memory
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] param;
    logic [CNT_W-1:0]        start;
    logic [CNT_W-1:0]        length;
  } slot_t;

  // Stage enables for the shared fault arithmetic unit
  typedef struct packed {
    logic mul;
    logic sum;
  } fu_ctl_t;

  // Flip one bit; index is the Q16.16 integer part, clamped to 0..31
  function automatic logic signed [VAL_W-1:0] bit_flip(
      input logic signed [VAL_W-1:0] v,
      input logic signed [VAL_W-1:0] p);
    logic [4:0] idx;
    if (p[VAL_W-1]) begin
      idx = 5'd0;
    end else if (|p[30:21]) begin
      idx = BIT_MAX;
    end else begin
      idx = p[20:16];
    end
    return v ^ (32'h1 << idx);
  endfunction

endpackage

// ===== hdl/pfi_slot_mem.sv =====
// Fault slot storage: one write port, one registered read port.
// Depends on pfi_pkg for the slot record type.
`timescale 1ns / 1ps

module pfi_slot_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pfi_pkg::slot_t wdata,
  input  logic [AW-1:0] raddr,
  output pfi_pkg::slot_t rdata
);
  import pfi_pkg::*;

  slot_t mem [DEPTH];
  slot_t rdata_r;

  // Write one slot per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/pfi_fault_unit.sv =====
// Shared fault arithmetic: one 32x32 multiplier, a Q16.16 sum stage and a
// truncate-and-saturate stage. Depends on pfi_pkg.
`timescale 1ns / 1ps

module pfi_fault_unit (
  input  logic                    clk,
  input  pfi_pkg::fu_ctl_t        ctl,
  input  logic [2:0]              kind,
  input  logic signed [31:0]      param,
  input  logic signed [31:0]      value,
  output logic signed [31:0]      result
);
  import pfi_pkg::*;

  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] mul;
  logic signed [63:0] prod_r;
  logic signed [31:0] addend_r;
  logic signed [63:0] sum_r;
  logic signed [63:0] biased;
  logic signed [63:0] shifted;

  // Gain: value*param; offset: value*65536 + param; set: 1*param
  always_comb begin
    op_a = (kind == KIND_SET) ? 32'sd1 : value;
    op_b = (kind == KIND_OFFSET) ? 32'sd65536 : param;
    mul  = op_a * op_b;
  end

  // Multiply stage, then add the offset term
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r   <= mul;
      addend_r <= (kind == KIND_OFFSET) ? param : 32'sd0;
    end
    if (ctl.sum) begin
      sum_r <= prod_r + {{32{addend_r[31]}}, addend_r};
    end
  end

  // Drop the fraction toward zero and saturate to 32 bits
  always_comb begin
    biased  = sum_r + (sum_r[63] ? 64'sd65535 : 64'sd0);
    shifted = biased >>> 16;
    if (&shifted[63:31] || ~|shifted[63:31]) begin
      result = shifted[31:0];
    end else if (shifted[63]) begin
      result = 32'sh8000_0000;
    end else begin
      result = 32'sh7FFF_FFFF;
    end
  end

endmodule

// ===== hdl/probe_fault_injector.sv =====
// Probe fault injector top level: probe table, sequencer and stream ports.
// Depends on pfi_pkg, pfi_slot_mem and pfi_fault_unit.
//
// Usage: items arrive on the in_ stream (opcode in tuser), one result per
// item leaves on the out_ stream. cfg_we/cfg_wdata write the enable bit.
// Inject walks the probe table one probe per cycle; for each matching used
// probe it walks its fault slots (read, check, next), adding multiply, sum
// and normalise steps for each offset, gain or set-to fault applied on the
// shared multiplier. Inject while disabled, clear and counter reset go
// straight to the final state. The block takes one item at a time;
// in_tready is high only when idle. Reset clears the probe table, slot
// used bits and enable; the block is ready right after. A finished result
// sits in the output register until taken, and a new item is accepted
// meanwhile; the next result then waits in its final state while
// out_tready stays low.
`timescale 1ns / 1ps

module probe_fault_injector #(
  parameter int PROBES          = 8,
  parameter int SLOTS_PER_PROBE = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // cfg: enable
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: probe_tag[15:0], value_in[47:16], fault_type[50:48],
  //        fault_param[82:51], start_offset[113:83], fault_length[144:114]
  input  logic [151:0] in_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: value_out[31:0]
  output logic [31:0]  out_tdata,
  // tuser: status[1:0], probe_hit[2]
  output logic [2:0]   out_tuser
);
  import pfi_pkg::*;

  localparam int NSLOT = PROBES * SLOTS_PER_PROBE;
  localparam int PIW   = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int SJW   = (SLOTS_PER_PROBE > 1) ? $clog2(SLOTS_PER_PROBE) : 1;
  localparam int SAW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  state_t state_r, state_nxt;
  logic   enable_r;

  // Probe table and slot used bits
  logic [TAG_W-1:0] probe_tags_r   [PROBES];
  logic [CNT_W-1:0] probe_counts_r [PROBES];
  logic [PROBES-1:0] probe_used_r;
  logic [NSLOT-1:0]  slot_used_r;

  // Captured item
  opcode_t                 op_r;
  logic [TAG_W-1:0]        tag_r;
  logic [KIND_W-1:0]       kind_r;
  logic signed [VAL_W-1:0] param_r;
  logic [CNT_W-1:0]        soff_r;
  logic [CNT_W-1:0]        flen_r;

  // Walk state
  logic [PIW-1:0]          pi_r;
  logic [SJW-1:0]          sj_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [VAL_W-1:0] res_r;
  logic                    hit_r;
  logic [1:0]              status_r;
  logic [PIW-1:0]          free_r;
  logic                    free_v_r;
  logic [PIW-1:0]          sel_r;

  // Output register
  logic             out_valid_r;
  logic [31:0]      out_value_r;
  logic [1:0]       out_status_r;
  logic             out_hit_r;

  logic             acc;
  opcode_t          in_op;
  logic             out_free;
  logic             pi_last;
  logic             sj_last;
  logic             cur_match;
  logic [SAW-1:0]   slot_addr;
  slot_t            rd;
  logic [CNT_W-1:0] win_diff;
  logic             win_act;
  logic [SJW-1:0]   fj;
  logic             fj_found;
  logic [SAW-1:0]   alloc_addr;
  logic [31:0]      st_sum;
  logic [CNT_W-1:0] st_sat;
  slot_t            wr;
  logic             mem_we;
  fu_ctl_t          fu_ctl;
  logic signed [31:0] fu_res;

  assign acc       = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_op     = opcode_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;
  assign pi_last   = (pi_r == PIW'(PROBES - 1));
  assign sj_last   = (sj_r == SJW'(SLOTS_PER_PROBE - 1));
  assign cur_match = probe_used_r[pi_r] && (probe_tags_r[pi_r] == tag_r);
  assign slot_addr = SAW'(int'(pi_r) * SLOTS_PER_PROBE + int'(sj_r));

  // Fault window check on the slot just read
  always_comb begin
    win_diff = cnt_r - rd.start;
    win_act  = slot_used_r[slot_addr] && (cnt_r >= rd.start) &&
               ((rd.length == '0) || (rd.length > win_diff));
  end

  // First free slot of the selected probe
  always_comb begin
    fj       = '0;
    fj_found = 1'b0;
    for (int j = SLOTS_PER_PROBE - 1; j >= 0; j--) begin
      if (!slot_used_r[SAW'(int'(sel_r) * SLOTS_PER_PROBE + j)]) begin
        fj       = SJW'(j);
        fj_found = 1'b1;
      end
    end
  end

  // Slot record for an add (start saturates at the counter limit), slot write enable and fault unit stage enables
  always_comb begin
    alloc_addr = SAW'(int'(sel_r) * SLOTS_PER_PROBE + int'(fj));
    st_sum     = {1'b0, soff_r} + {1'b0, probe_counts_r[sel_r]};
    st_sat     = st_sum[31] ? CNT_MAX : st_sum[CNT_W-1:0];
    wr.kind    = kind_r;
    wr.param   = param_r;
    wr.start   = st_sat;
    wr.length  = flen_r;
    mem_we     = (state_r == ST_AALLOC) && fj_found;
    fu_ctl.mul = (state_r == ST_MUL);
    fu_ctl.sum = (state_r == ST_SUM);
  end

  pfi_slot_mem #(
    .DEPTH (NSLOT),
    .AW    (SAW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (alloc_addr),
    .wdata (wr),
    .raddr (slot_addr),
    .rdata (rd)
  );

  pfi_fault_unit u_fault_unit (
    .clk    (clk),
    .ctl    (fu_ctl),
    .kind   (rd.kind),
    .param  (rd.param),
    .value  (res_r),
    .result (fu_res)
  );

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_INJECT: state_nxt = enable_r ? ST_PSCAN : ST_DONE;
            OP_ADD:    state_nxt = ST_AFIND;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PSCAN: begin
        if (cur_match) begin
          state_nxt = ST_SREAD;
        end else if (pi_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SREAD: state_nxt = ST_SCHECK;
      ST_SCHECK: begin
        if (win_act && (rd.kind == KIND_OFFSET || rd.kind == KIND_GAIN ||
                        rd.kind == KIND_SET)) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SNEXT;
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_NORM;
      ST_NORM: state_nxt = ST_SNEXT;
      ST_SNEXT: begin
        if (!sj_last) begin
          state_nxt = ST_SREAD;
        end else if (pi_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PSCAN;
        end
      end
      ST_AFIND: begin
        if (probe_tags_r[pi_r] == tag_r) begin
          state_nxt = ST_AALLOC;
        end else if (pi_last) begin
          state_nxt = (free_v_r || !probe_used_r[pi_r]) ? ST_AALLOC : ST_DONE;
        end
      end
      ST_AALLOC: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and probe table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      enable_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      probe_used_r <= '0;
      slot_used_r  <= '0;
      for (int i = 0; i < PROBES; i++) begin
        probe_tags_r[i]   <= '0;
        probe_counts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      // Drop the result once transferred, load the next one when done
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc && in_op == OP_CLEAR) begin
            probe_used_r <= '0;
            slot_used_r  <= '0;
          end
          if (acc && (in_op == OP_CLEAR || in_op == OP_RSTCNT)) begin
            for (int i = 0; i < PROBES; i++) begin
              probe_counts_r[i] <= '0;
            end
          end
        end
        ST_SNEXT: begin
          if (sj_last) begin
            probe_counts_r[pi_r] <= (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
          end
        end
        ST_AALLOC: begin
          probe_used_r[sel_r] <= 1'b1;
          probe_tags_r[sel_r] <= tag_r;
          if (fj_found) begin
            slot_used_r[alloc_addr] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture, walk registers and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          op_r     <= in_op;
          tag_r    <= in_tdata[15:0];
          kind_r   <= in_tdata[50:48];
          param_r  <= in_tdata[82:51];
          soff_r   <= in_tdata[113:83];
          flen_r   <= in_tdata[144:114];
          res_r    <= (in_op == OP_INJECT) ? in_tdata[47:16] : 32'sd0;
          hit_r    <= 1'b0;
          status_r <= STAT_OK;
          pi_r     <= '0;
          free_v_r <= 1'b0;
        end
      end
      ST_PSCAN: begin
        if (cur_match) begin
          hit_r <= 1'b1;
          cnt_r <= probe_counts_r[pi_r];
          sj_r  <= '0;
        end else if (!pi_last) begin
          pi_r <= pi_r + 1'b1;
        end
      end
      ST_SCHECK: begin
        if (win_act && rd.kind == KIND_BITFLIP) begin
          res_r <= bit_flip(res_r, rd.param);
        end
      end
      ST_NORM: res_r <= fu_res;
      ST_SNEXT: begin
        if (!sj_last) begin
          sj_r <= sj_r + 1'b1;
        end else if (!pi_last) begin
          pi_r <= pi_r + 1'b1;
        end
      end
      ST_AFIND: begin
        if (probe_tags_r[pi_r] == tag_r) begin
          sel_r <= pi_r;
        end else begin
          if (!probe_used_r[pi_r] && !free_v_r) begin
            free_r   <= pi_r;
            free_v_r <= 1'b1;
          end
          if (pi_last) begin
            if (free_v_r) begin
              sel_r <= free_r;
            end else if (!probe_used_r[pi_r]) begin
              sel_r <= pi_r;
            end else begin
              status_r <= STAT_NOPROBE;
            end
          end else begin
            pi_r <= pi_r + 1'b1;
          end
        end
      end
      ST_AALLOC: begin
        if (!fj_found) begin
          status_r <= STAT_NOSLOT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_value_r  <= res_r;
          out_status_r <= status_r;
          out_hit_r    <= hit_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_hit_r, out_status_r};

  // A result appears only out of the final state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the final state");

  // A hit never carries an add status
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_status_r != STAT_OK))
    else $error("probe hit reported with nonzero status");

  // A clear empties the probe and slot tables at once
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_CLEAR) |=> (probe_used_r == '0 && slot_used_r == '0))
    else $error("clear left used probes or slots");

  // A slot is checked only after its read cycle
  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCHECK) |-> $past(state_r == ST_SREAD))
    else $error("slot checked without a read cycle");

  // The fault unit sum stage always follows its multiply stage
  a_fu_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> $past(state_r == ST_MUL && op_r == OP_INJECT))
    else $error("fault sum stage without a multiply");

endmodule
